FILE: src/trs_pkg.sv
// shared types and constants for the trs affine matrix builder
`default_nettype none
package trs_pkg;

   // divider depth: one quotient bit per stage
   localparam int DIV_STAGES = 32;
   // column pipe: divider, quotient round, scale product, final round
   localparam int COL_STAGES = DIV_STAGES + 3;

   localparam logic [1:0] COL_TRANS = 2'd3;

   // one transaction after quaternion normalization and products
   typedef struct packed {
      logic                  zero;
      logic [2:0][31:0]      trans;
      logic [2:0][31:0]      scale;
      logic [2:0][2:0][63:0] num;   // [col][row], signed
      logic [61:0]           den;
   } front_item_type;

   // per-column control carried beside the divider lanes
   typedef struct packed {
      logic [1:0]       col;
      logic             last;
      logic             status;
      logic [2:0]       neg;
      logic [61:0]      den;
      logic [2:0][31:0] smag;
   } col_meta_type;

   // one column handed to the column pipe
   typedef struct packed {
      col_meta_type     meta;
      logic [2:0][62:0] nmag;
   } col_item_type;

endpackage
`default_nettype wire

FILE: src/trs_to_affine_matrix.sv
// top level of the trs affine matrix builder
//
// Builds the 4x4 affine matrix T*R*S from a translation, a quaternion and a
// scale, all signed Q16.16 (FRAC_BITS fraction bits), and sends it as four
// column transactions (column 3 is the translation over 1.0). A quaternion of
// zero length yields one transaction with status set and zero elements.
// The pipeline has 6 front stages, one expander register and 35 column stages.
// The result port carries one column per cycle when not stalled, so a
// transaction takes four columns (one for a rejected quaternion); the expander
// that splits a transaction into columns sets that rate. A stall on the result
// side fills empty pipeline slots before the input side is stalled.
`default_nettype none
module trs_to_affine_matrix import trs_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [31:0] req_trans_x,
   input  wire logic [31:0] req_trans_y,
   input  wire logic [31:0] req_trans_z,
   input  wire logic [31:0] req_quat_w,
   input  wire logic [31:0] req_quat_x,
   input  wire logic [31:0] req_quat_y,
   input  wire logic [31:0] req_quat_z,
   input  wire logic [31:0] req_scale_x,
   input  wire logic [31:0] req_scale_y,
   input  wire logic [31:0] req_scale_z,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_column_index,
   output logic [31:0]      rsp_elem_row0,
   output logic [31:0]      rsp_elem_row1,
   output logic [31:0]      rsp_elem_row2,
   output logic [31:0]      rsp_elem_row3,
   output logic             rsp_last_column,
   output logic             rsp_status
);

   localparam logic [31:0] ONE = 32'd1 << FRAC_BITS;

   logic             front_ready;
   logic             front_valid;
   front_item_type   front_item;
   logic             exp_ready;
   logic             col_valid;
   logic             col_ready;
   col_item_type     col_item;
   logic [2:0][31:0] elem;

   // normalize and form numerators
   trs_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (front_ready),
      .in_quat   ({req_quat_z, req_quat_y, req_quat_x, req_quat_w}),
      .in_trans  ({req_trans_z, req_trans_y, req_trans_x}),
      .in_scale  ({req_scale_z, req_scale_y, req_scale_x}),
      .out_valid (front_valid),
      .out_ready (exp_ready),
      .out_item  (front_item)
   );
   assign req_stall = !front_ready;

   // split into columns
   trs_expand u_expand (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (exp_ready),
      .in_item   (front_item),
      .out_valid (col_valid),
      .out_ready (col_ready),
      .out_item  (col_item)
   );

   // per-column divide and scale
   trs_col_pipe u_col (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (col_valid),
      .in_ready   (col_ready),
      .in_item    (col_item),
      .out_valid  (rsp_valid),
      .out_stall  (rsp_stall),
      .out_col    (rsp_column_index),
      .out_last   (rsp_last_column),
      .out_status (rsp_status),
      .out_elem   (elem)
   );

   assign rsp_elem_row0 = elem[0];
   assign rsp_elem_row1 = elem[1];
   assign rsp_elem_row2 = elem[2];
   assign rsp_elem_row3 = (rsp_column_index == COL_TRANS && !rsp_status) ? ONE : 32'd0;

endmodule
`default_nettype wire

FILE: src/trs_front.sv
// front pipeline: magnitudes, zero check, normalize, products, numerators
`default_nettype none
module trs_front import trs_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire logic [3:0][31:0]      in_quat,
   input  wire logic [2:0][31:0]      in_trans,
   input  wire logic [2:0][31:0]      in_scale,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output front_item_type             out_item
);

   localparam logic [63:0] ZERO_LIM = (64'd1 << (2 * FRAC_BITS)) / 64'd1000000000000;
   localparam int NST = 6;

   logic [NST-1:0] v_ff;
   logic [NST-1:0] rdy;

   // stage registers
   logic [3:0][31:0] m1_ff, m2_ff, m3_ff;
   logic [3:0]       ng1_ff, ng2_ff, ng3_ff;
   logic [2:0][31:0] t1_ff, t2_ff, t3_ff, t4_ff, t5_ff, t6_ff;
   logic [2:0][31:0] s1_ff, s2_ff, s3_ff, s4_ff, s5_ff, s6_ff;
   logic [31:0]      mx2_ff;
   logic             small2_ff;
   logic [23:0]      sq2_ff;
   logic             zero3_ff, zero4_ff, zero5_ff, zero6_ff;
   logic [4:0]       pos3_ff;
   logic signed [31:0] q4_ff [4];
   logic signed [63:0] pr5_ff [10];
   logic [2:0][2:0][63:0] num6_ff;
   logic [61:0]      den6_ff;

   logic [3:0][31:0] m1_in;
   logic [3:0]       ng1_in;
   logic [31:0]      mx2_in;
   logic [23:0]      sq2_in;
   logic [4:0]       pos3_in;
   logic signed [31:0] q4_in [4];
   logic signed [63:0] pr5_in [10];
   logic [2:0][2:0][63:0] num6_in;
   logic [61:0]      den6_in;
   logic [31:0]      sh;
   logic signed [63:0] ww, xx, yy, zz, xy, xz, yz, wx, wy, wz;

   // ready chain, a stage moves when empty or draining
   always_comb begin
      rdy[NST-1] = !v_ff[NST-1] || out_ready;
      for (int k = NST - 2; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < NST; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // stage logic
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         ng1_in[i] = in_quat[i][31];
         m1_in[i]  = in_quat[i][31] ? (32'd0 - in_quat[i]) : in_quat[i];
      end
      mx2_in = m1_ff[0];
      for (int i = 1; i < 4; i++) begin
         if (m1_ff[i] > mx2_in) begin
            mx2_in = m1_ff[i];
         end
      end
      sq2_in = '0;
      for (int i = 0; i < 4; i++) begin
         sq2_in = sq2_in + 24'({11'd0, m1_ff[i][10:0]} * {11'd0, m1_ff[i][10:0]});
      end
      pos3_in = '0;
      for (int b = 0; b < 32; b++) begin
         if (mx2_ff[b]) begin
            pos3_in = 5'(b);
         end
      end
      for (int i = 0; i < 4; i++) begin
         if (pos3_ff >= 5'd29) begin
            sh = m3_ff[i] >> (pos3_ff - 5'd29);
         end else begin
            sh = m3_ff[i] << (5'd29 - pos3_ff);
         end
         q4_in[i] = ng3_ff[i] ? -$signed({2'b00, sh[29:0]}) : $signed({2'b00, sh[29:0]});
      end
      pr5_in[0] = q4_ff[0] * q4_ff[0];
      pr5_in[1] = q4_ff[1] * q4_ff[1];
      pr5_in[2] = q4_ff[2] * q4_ff[2];
      pr5_in[3] = q4_ff[3] * q4_ff[3];
      pr5_in[4] = q4_ff[1] * q4_ff[2];
      pr5_in[5] = q4_ff[1] * q4_ff[3];
      pr5_in[6] = q4_ff[2] * q4_ff[3];
      pr5_in[7] = q4_ff[0] * q4_ff[1];
      pr5_in[8] = q4_ff[0] * q4_ff[2];
      pr5_in[9] = q4_ff[0] * q4_ff[3];
      ww = pr5_ff[0]; xx = pr5_ff[1]; yy = pr5_ff[2]; zz = pr5_ff[3];
      xy = pr5_ff[4]; xz = pr5_ff[5]; yz = pr5_ff[6];
      wx = pr5_ff[7]; wy = pr5_ff[8]; wz = pr5_ff[9];
      den6_in = 62'(ww + xx + yy + zz);
      num6_in[0][0] = ww + xx - yy - zz;
      num6_in[0][1] = (xy + wz) <<< 1;
      num6_in[0][2] = (xz - wy) <<< 1;
      num6_in[1][0] = (xy - wz) <<< 1;
      num6_in[1][1] = ww - xx + yy - zz;
      num6_in[1][2] = (yz + wx) <<< 1;
      num6_in[2][0] = (xz + wy) <<< 1;
      num6_in[2][1] = (yz - wx) <<< 1;
      num6_in[2][2] = ww - xx - yy + zz;
   end

   // stage registers, payload only
   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         m1_ff  <= m1_in;
         ng1_ff <= ng1_in;
         t1_ff  <= in_trans;
         s1_ff  <= in_scale;
      end
      if (rdy[1]) begin
         m2_ff     <= m1_ff;
         ng2_ff    <= ng1_ff;
         t2_ff     <= t1_ff;
         s2_ff     <= s1_ff;
         mx2_ff    <= mx2_in;
         sq2_ff    <= sq2_in;
         small2_ff <= (mx2_in[31:10] == '0);
      end
      if (rdy[2]) begin
         m3_ff    <= m2_ff;
         ng3_ff   <= ng2_ff;
         t3_ff    <= t2_ff;
         s3_ff    <= s2_ff;
         pos3_ff  <= pos3_in;
         zero3_ff <= small2_ff && ({40'd0, sq2_ff} <= ZERO_LIM);
      end
      if (rdy[3]) begin
         for (int i = 0; i < 4; i++) begin
            q4_ff[i] <= q4_in[i];
         end
         t4_ff    <= t3_ff;
         s4_ff    <= s3_ff;
         zero4_ff <= zero3_ff;
      end
      if (rdy[4]) begin
         for (int i = 0; i < 10; i++) begin
            pr5_ff[i] <= pr5_in[i];
         end
         t5_ff    <= t4_ff;
         s5_ff    <= s4_ff;
         zero5_ff <= zero4_ff;
      end
      if (rdy[5]) begin
         num6_ff  <= num6_in;
         den6_ff  <= den6_in;
         t6_ff    <= t5_ff;
         s6_ff    <= s5_ff;
         zero6_ff <= zero5_ff;
      end
   end

   assign out_valid      = v_ff[NST-1];
   assign out_item.zero  = zero6_ff;
   assign out_item.trans = t6_ff;
   assign out_item.scale = s6_ff;
   assign out_item.num   = num6_ff;
   assign out_item.den   = den6_ff;

endmodule
`default_nettype wire

FILE: src/trs_expand.sv
// column expander: holds one transaction, issues one column per out_ready cycle
`default_nettype none
module trs_expand import trs_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire front_item_type in_item,
   output logic                out_valid,
   input  wire logic           out_ready,
   output col_item_type        out_item
);

   front_item_type hold_ff;
   logic           hv_ff;
   logic [1:0]     cnt_ff;
   logic           last;
   logic [63:0]    n;
   logic [31:0]    s;

   assign last     = hold_ff.zero || (cnt_ff == COL_TRANS);
   assign in_ready = !hv_ff || (out_ready && last);
   assign out_valid = hv_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hv_ff  <= 1'b0;
         cnt_ff <= '0;
      end else if (in_ready) begin
         hv_ff  <= in_valid;
         cnt_ff <= '0;
      end else if (out_ready) begin
         cnt_ff <= cnt_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) begin
         hold_ff <= in_item;
      end
   end

   // translation column divides den by itself, giving exactly one
   always_comb begin
      out_item.meta.col    = hold_ff.zero ? 2'd0 : cnt_ff;
      out_item.meta.last   = last;
      out_item.meta.status = hold_ff.zero;
      out_item.meta.den    = hold_ff.den;
      for (int j = 0; j < 3; j++) begin
         if (cnt_ff == COL_TRANS) begin
            n = {2'b00, hold_ff.den};
            s = hold_ff.trans[j];
         end else begin
            n = hold_ff.num[cnt_ff][j];
            s = hold_ff.scale[cnt_ff];
         end
         out_item.nmag[j]      = n[63] ? 63'(64'd0 - n) : n[62:0];
         out_item.meta.smag[j] = s[31] ? (32'd0 - s) : s;
         out_item.meta.neg[j]  = n[63] ^ s[31];
      end
   end

endmodule
`default_nettype wire

FILE: src/trs_col_pipe.sv
// column pipeline: bit-per-stage ratio, rounding, scale product, saturation
`default_nettype none
module trs_col_pipe import trs_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         in_valid,
   output logic              in_ready,
   input  wire col_item_type in_item,
   output logic              out_valid,
   input  wire logic         out_stall,
   output logic [1:0]        out_col,
   output logic              out_last,
   output logic              out_status,
   output logic [2:0][31:0]  out_elem
);

   localparam int RND = DIV_STAGES;
   localparam int MUL = DIV_STAGES + 1;
   localparam int FIN = DIV_STAGES + 2;

   logic [COL_STAGES-1:0] v_ff;
   logic [COL_STAGES-1:0] rdy;
   col_meta_type          meta_ff [COL_STAGES];

   logic [2:0][62:0] r_ff [DIV_STAGES];
   logic [2:0][31:0] q_ff [DIV_STAGES];
   logic [2:0][62:0] r_in [DIV_STAGES];
   logic [2:0][31:0] q_in [DIV_STAGES];
   logic [2:0][30:0] r30_ff, r30_in;
   logic [2:0][62:0] p_ff, p_in;
   logic [2:0][31:0] e_ff, e_in;

   logic [62:0] rr;
   logic [62:0] dd;
   logic [31:0] qp;
   logic [32:0] qs;
   logic [63:0] ms;
   logic [33:0] m;

   // ready chain
   always_comb begin
      rdy[COL_STAGES-1] = !v_ff[COL_STAGES-1] || !out_stall;
      for (int k = COL_STAGES - 2; k >= 0; k--) begin
         rdy[k] = !v_ff[k] || rdy[k+1];
      end
   end
   assign in_ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (rdy[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < COL_STAGES; k++) begin
            if (rdy[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // restoring divide, one quotient bit per stage per lane
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         rr = in_item.nmag[j];
         dd = {1'b0, in_item.meta.den};
         if (rr >= dd) begin
            r_in[0][j] = rr - dd;
            q_in[0][j] = 32'd1;
         end else begin
            r_in[0][j] = rr;
            q_in[0][j] = 32'd0;
         end
      end
      for (int k = 1; k < DIV_STAGES; k++) begin
         for (int j = 0; j < 3; j++) begin
            rr = {r_ff[k-1][j][61:0], 1'b0};
            dd = {1'b0, meta_ff[k-1].den};
            qp = q_ff[k-1][j];
            if (rr >= dd) begin
               r_in[k][j] = rr - dd;
               q_in[k][j] = {qp[30:0], 1'b1};
            end else begin
               r_in[k][j] = rr;
               q_in[k][j] = {qp[30:0], 1'b0};
            end
         end
      end
   end

   // round quotient, scale product, round and saturate
   always_comb begin
      for (int j = 0; j < 3; j++) begin
         qs = {1'b0, q_ff[DIV_STAGES-1][j]} + 33'd1;
         r30_in[j] = qs[31:1];
         p_in[j] = {32'd0, r30_ff[j]} * {31'd0, meta_ff[MUL-1].smag[j]};
         ms = {1'b0, p_ff[j]} + (64'd1 << 29);
         m  = ms[63:30];
         if (meta_ff[FIN-1].status) begin
            e_in[j] = '0;
         end else if (meta_ff[FIN-1].neg[j]) begin
            if (m > 34'h080000000) begin
               e_in[j] = 32'h80000000;
            end else begin
               e_in[j] = 32'd0 - m[31:0];
            end
         end else if (m > 34'h07FFFFFFF) begin
            e_in[j] = 32'h7FFFFFFF;
         end else begin
            e_in[j] = m[31:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy[0]) begin
         meta_ff[0] <= in_item.meta;
      end
      for (int k = 1; k < COL_STAGES; k++) begin
         if (rdy[k]) begin
            meta_ff[k] <= meta_ff[k-1];
         end
      end
      for (int k = 0; k < DIV_STAGES; k++) begin
         if (rdy[k]) begin
            r_ff[k] <= r_in[k];
            q_ff[k] <= q_in[k];
         end
      end
      if (rdy[RND]) begin
         r30_ff <= r30_in;
      end
      if (rdy[MUL]) begin
         p_ff <= p_in;
      end
      if (rdy[FIN]) begin
         e_ff <= e_in;
      end
   end

   assign out_valid  = v_ff[COL_STAGES-1];
   assign out_col    = meta_ff[COL_STAGES-1].col;
   assign out_last   = meta_ff[COL_STAGES-1].last;
   assign out_status = meta_ff[COL_STAGES-1].status;
   assign out_elem   = e_ff;

endmodule
`default_nettype wire

FILE: test/trs_to_affine_matrix_test.sv
// testbench for the trs affine matrix builder: random and directed transforms
`timescale 1ns / 100ps
`default_nettype none
module trs_to_affine_matrix_test import trs_pkg::*;;

   localparam int FRAC = 16;
   localparam int LATENCY = 60;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS = 350;

   typedef struct packed {
      logic [2:0][31:0] trans;
      logic [3:0][31:0] quat;   // w, x, y, z
      logic [2:0][31:0] scale;
   } transform_type;

   typedef struct packed {
      logic [1:0]  col;
      logic [31:0] row0;
      logic [31:0] row1;
      logic [31:0] row2;
      logic [31:0] row3;
      logic        last;
      logic        status;
   } column_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   transform_type req_cur = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [1:0] rsp_column_index;
   logic [31:0] rsp_elem_row0, rsp_elem_row1, rsp_elem_row2, rsp_elem_row3;
   logic rsp_last_column, rsp_status;

   transform_type pending_transforms[$];
   column_type expected_columns[$];
   int mismatches = 0;
   int columns_seen = 0;
   int rejects_seen = 0;
   int transforms_sent = 0;
   int idle_cycles = 0;
   bit random_idle = 0;
   int long_hold = 0;

   always #2 clock = ~clock;

   trs_to_affine_matrix uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_trans_x(req_cur.trans[0]), .req_trans_y(req_cur.trans[1]),
      .req_trans_z(req_cur.trans[2]),
      .req_quat_w(req_cur.quat[0]), .req_quat_x(req_cur.quat[1]),
      .req_quat_y(req_cur.quat[2]), .req_quat_z(req_cur.quat[3]),
      .req_scale_x(req_cur.scale[0]), .req_scale_y(req_cur.scale[1]),
      .req_scale_z(req_cur.scale[2]),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_column_index(rsp_column_index),
      .rsp_elem_row0(rsp_elem_row0), .rsp_elem_row1(rsp_elem_row1),
      .rsp_elem_row2(rsp_elem_row2), .rsp_elem_row3(rsp_elem_row3),
      .rsp_last_column(rsp_last_column), .rsp_status(rsp_status)
   );

   // exact quotient n/d with 30 fraction bits, rounded to nearest
   function automatic logic [63:0] unit_ratio(logic [63:0] n, logic [63:0] d);
      logic [63:0] q;
      logic [63:0] r;
      q = 0;
      r = n;
      if (r >= d) begin
         r -= d;
         q = 1;
      end
      for (int i = 0; i < 31; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= d) begin
            r -= d;
            q[0] = 1;
         end
      end
      return (q + 1) >> 1;
   endfunction

   function automatic logic [63:0] magnitude(logic signed [63:0] v);
      return v < 0 ? -v : v;
   endfunction

   // one rotation entry times its scale, rounded and saturated
   function automatic logic [31:0] rotated_element(logic signed [63:0] num, logic [63:0] den,
                                                   logic signed [31:0] scl);
      logic [63:0] prod;
      logic [63:0] m;
      logic signed [63:0] sscl;
      sscl = scl;
      prod = unit_ratio(magnitude(num), den) * magnitude(sscl);
      m = (prod + (64'd1 << 29)) >> 30;
      if ((num < 0) != (scl < 0)) begin
         if (m > 64'h8000_0000) m = 64'h8000_0000;
         return 32'(-m);
      end
      if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
      return m[31:0];
   endfunction

   // expected columns of one transform
   task automatic predict_matrix(transform_type t);
      logic [63:0] m[4];
      logic neg[4];
      logic [63:0] mx, sq, den;
      logic signed [63:0] q[4];
      logic signed [63:0] w, x, y, z;
      logic signed [63:0] num[3][3];
      logic signed [31:0] sq32;
      column_type c;
      mx = 0;
      for (int i = 0; i < 4; i++) begin
         sq32 = t.quat[i];
         neg[i] = sq32 < 0;
         m[i] = magnitude(64'(sq32));
         if (m[i] > mx) mx = m[i];
      end
      if (mx < 1024) begin
         sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2] + m[3] * m[3];
         if (sq * 64'd1000000000000 <= (64'd1 << (2 * FRAC))) begin
            c = '0;
            c.last = 1;
            c.status = 1;
            expected_columns.push_back(c);
            return;
         end
      end
      while (mx < (64'd1 << 29)) begin
         mx = mx << 1;
         for (int i = 0; i < 4; i++) m[i] = m[i] << 1;
      end
      while (mx >= (64'd1 << 30)) begin
         mx = mx >> 1;
         for (int i = 0; i < 4; i++) m[i] = m[i] >> 1;
      end
      for (int i = 0; i < 4; i++) q[i] = neg[i] ? -m[i] : m[i];
      w = q[0]; x = q[1]; y = q[2]; z = q[3];
      den = w * w + x * x + y * y + z * z;
      num[0][0] = w * w + x * x - y * y - z * z;
      num[0][1] = 2 * (x * y + w * z);
      num[0][2] = 2 * (x * z - w * y);
      num[1][0] = 2 * (x * y - w * z);
      num[1][1] = w * w - x * x + y * y - z * z;
      num[1][2] = 2 * (y * z + w * x);
      num[2][0] = 2 * (x * z + w * y);
      num[2][1] = 2 * (y * z - w * x);
      num[2][2] = w * w - x * x - y * y + z * z;
      for (int i = 0; i < 3; i++) begin
         c = '0;
         c.col = 2'(i);
         c.row0 = rotated_element(num[i][0], den, t.scale[i]);
         c.row1 = rotated_element(num[i][1], den, t.scale[i]);
         c.row2 = rotated_element(num[i][2], den, t.scale[i]);
         expected_columns.push_back(c);
      end
      c = '0;
      c.col = COL_TRANS;
      c.row0 = t.trans[0];
      c.row1 = t.trans[1];
      c.row2 = t.trans[2];
      c.row3 = 32'd1 << FRAC;
      c.last = 1;
      expected_columns.push_back(c);
   endtask

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      mismatches++;
   endtask

   // driver: new transaction at the falling edge once the previous one is taken
   int send_gap = 0;
   logic req_taken = 0;
   always @(posedge clock) req_taken <= req_valid && !req_stall && !reset;
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_taken)) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_valid <= 0;
         end else if (pending_transforms.size() > 0) begin
            req_cur <= pending_transforms.pop_front();
            req_valid <= 1;
            if (random_idle && $urandom_range(0, 9) == 0) send_gap <= $urandom_range(1, 18);
         end else begin
            req_valid <= 0;
         end
      end
   end

   // prediction on every accepted transaction
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         predict_matrix(req_cur);
         transforms_sent++;
      end
   end

   // receiver stall control
   int stall_left = 0;
   always @(negedge clock) begin
      if (long_hold > 0) begin
         long_hold <= long_hold - 1;
         rsp_stall <= 1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1;
      end else if (random_idle && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 17);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   // monitor: compare each column with the oldest expectation
   always @(posedge clock) begin
      column_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         columns_seen++;
         if (rsp_status) rejects_seen++;
         if (expected_columns.size() == 0) begin
            $display("unexpected column transaction");
            mismatches++;
         end else begin
            want = expected_columns.pop_front();
            if (rsp_column_index !== want.col) report_mismatch("column", rsp_column_index, want.col);
            if (rsp_elem_row0 !== want.row0) report_mismatch("row0", rsp_elem_row0, want.row0);
            if (rsp_elem_row1 !== want.row1) report_mismatch("row1", rsp_elem_row1, want.row1);
            if (rsp_elem_row2 !== want.row2) report_mismatch("row2", rsp_elem_row2, want.row2);
            if (rsp_elem_row3 !== want.row3) report_mismatch("row3", rsp_elem_row3, want.row3);
            if (rsp_last_column !== want.last) report_mismatch("last", rsp_last_column, want.last);
            if (rsp_status !== want.status) report_mismatch("status", rsp_status, want.status);
         end
      end
   end

   // watchdog on cycles with no transaction on either side
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout");
         $display("FAIL trs_to_affine_matrix");
         $finish;
      end
   end

   function automatic logic [31:0] random_word();
      case ($urandom_range(0, 5))
         0: return $urandom;
         1: return $urandom_range(0, 2047) - 1024;
         2: return 32'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
         3: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      endcase
   endfunction

   function automatic transform_type random_transform();
      transform_type t;
      for (int i = 0; i < 3; i++) begin
         t.trans[i] = random_word();
         t.scale[i] = random_word();
      end
      for (int i = 0; i < 4; i++) t.quat[i] = random_word();
      if ($urandom_range(0, 19) == 0) t.quat = '0;
      if ($urandom_range(0, 19) == 0)
         for (int i = 0; i < 4; i++) t.quat[i] = $urandom_range(0, 2) - 1;
      return t;
   endfunction

   function automatic transform_type make_transform(logic [31:0] tv, logic [31:0] w,
                                                    logic [31:0] x, logic [31:0] y,
                                                    logic [31:0] z, logic [31:0] sv);
      transform_type t;
      t.trans = {tv, ~tv, tv};
      t.quat = {z, y, x, w};
      t.scale = {sv, sv, sv};
      return t;
   endfunction

   task automatic wait_drained();
      while (pending_transforms.size() > 0 || req_valid || expected_columns.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      transform_type t;
      repeat (2) @(posedge clock);
      reset <= 0;

      // directed: identity, zero and tiny quaternions, extremes of every field
      pending_transforms.push_back(make_transform(0, 32'h1_0000, 0, 0, 0, 32'h1_0000));
      pending_transforms.push_back(make_transform(32'h7FFF_FFFF, 0, 0, 0, 0, 32'h1_0000));
      pending_transforms.push_back(make_transform(32'h8000_0000, 1, 0, 0, 0, 32'h1_0000));
      pending_transforms.push_back(make_transform(5, 0, 0, 0, 32'hFFFF_FFFF, 32'h2_0000));
      pending_transforms.push_back(make_transform(7, 65, 0, 0, 0, 32'h1_0000));
      pending_transforms.push_back(make_transform(7, 66, 0, 0, 0, 32'h1_0000));
      pending_transforms.push_back(make_transform(1, 32'h8000_0000, 0, 0, 0, 32'h7FFF_FFFF));
      pending_transforms.push_back(make_transform(2, 32'h7FFF_FFFF, 32'h8000_0000,
                                                  32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000));
      pending_transforms.push_back(make_transform(3, 0, 32'h1_0000, 0, 0, 32'hFFFF_0000));
      pending_transforms.push_back(make_transform(4, 0, 0, 32'h1_0000, 0, 32'h7FFF_FFFF));
      pending_transforms.push_back(make_transform(6, 0, 0, 0, 32'h1_0000, 32'h8000_0000));
      pending_transforms.push_back(make_transform(8, 32'hB505, 32'hB505, 0, 0, 32'h3_0000));
      pending_transforms.push_back(make_transform(9, 32'hFFFF, 32'hFFFF, 32'hFFFF,
                                                  32'hFFFF, 0));
      pending_transforms.push_back(make_transform(32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                                  32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                                  32'hFFFF_FFFF, 32'hFFFF_FFFF));
      wait_drained();

      // long receiver hold while the sender keeps going
      long_hold = 300;
      for (int i = 0; i < 40; i++) pending_transforms.push_back(random_transform());
      wait_drained();

      // random part with idling on both sides
      random_idle = 1;
      for (int i = 0; i < RANDOM_ITEMS - 80; i++) pending_transforms.push_back(random_transform());
      wait_drained();

      // closing part without idling
      random_idle = 0;
      for (int i = 0; i < 40; i++) pending_transforms.push_back(random_transform());
      wait_drained();
      repeat (LATENCY) @(posedge clock);

      $display("sent %0d transforms, checked %0d column transactions (%0d rejected quaternions)",
               transforms_sent, columns_seen, rejects_seen);
      if (mismatches == 0 && expected_columns.size() == 0) begin
         $display("PASS trs_to_affine_matrix");
      end else begin
         $display("FAIL trs_to_affine_matrix");
      end
      $finish;
   end
endmodule
`default_nettype wire
